// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, constants and helper functions for the caption byte pair
// classifier.
// ----------------------------------------------------------------------------
package cpc_pkg;

	// Result kind codes
	localparam logic [3:0] KIND_IGNORED      = 4'd0;
	localparam logic [3:0] KIND_PAC          = 4'd1;
	localparam logic [3:0] KIND_BAD_PAC      = 4'd2;
	localparam logic [3:0] KIND_ATTRIBUTE    = 4'd3;
	localparam logic [3:0] KIND_CONTROL      = 4'd4;
	localparam logic [3:0] KIND_UNKNOWN_CTRL = 4'd5;
	localparam logic [3:0] KIND_SPECIAL_NA   = 4'd6;
	localparam logic [3:0] KIND_SPECIAL_SF   = 4'd7;
	localparam logic [3:0] KIND_SPECIAL_PG   = 4'd8;
	localparam logic [3:0] KIND_CHARS        = 4'd9;
	localparam logic [3:0] KIND_TAB          = 4'd10;
	localparam logic [3:0] KIND_NONDATA      = 4'd11;

	// Padding header codes and the substitute for a first byte with bad parity
	localparam logic [7:0] HDR_PAD_A   = 8'hfa;
	localparam logic [7:0] HDR_PAD_B   = 8'hfc;
	localparam logic [7:0] HDR_PAD_C   = 8'hfd;
	localparam logic [6:0] BAD_PARITY_SUB = 7'h7f;

	// Row map plus one, indexed by PAC index; zero marks the index with no row
	localparam logic [3:0] ROW_PLUS_ONE [16] = '{
		4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd12, 4'd13,
		4'd14, 4'd15, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
	};

	// Pair after header and parity screening, parity bits stripped
	typedef struct packed {
		logic       drop;
		logic [6:0] b1;
		logic [6:0] b2;
	} cpc_pair_t;

	// One decoded result
	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] pac_index;
		logic [3:0] row;
		logic [2:0] color;
		logic [1:0] style;
		logic [4:0] indent;
		logic [3:0] attribute_index;
		logic [3:0] control_code;
		logic [1:0] tab_spaces;
		logic [6:0] char_first;
		logic [6:0] char_second;
	} cpc_result_t;

	// Color from a five-bit attribute code
	function automatic logic [2:0] color_of(input logic [4:0] code);
		logic [3:0] half;
		half = code[4:1];
		if (half >= 4'd1 && half <= 4'd6) begin
			color_of = 3'(half - 4'd1);
		end else begin
			color_of = 3'd6;
		end
	endfunction

	// Style from a five-bit attribute code
	function automatic logic [1:0] style_of(input logic [4:0] code);
		priority if (code == 5'd14) begin
			style_of = 2'd2;
		end else if (code == 5'd15) begin
			style_of = 2'd3;
		end else if (code[0]) begin
			style_of = 2'd1;
		end else begin
			style_of = 2'd0;
		end
	endfunction

endpackage

// ----- rtl/caption_608_pair_classifier.sv -----
// ----------------------------------------------------------------------------
// caption_608_pair_classifier
// Closed-caption byte pair classifier, one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive command, header_byte, first_byte and second_byte
//   and raise start; the transaction is taken at a rising edge with start
//   high and busy low. busy is always low, so a transaction may be started
//   in every cycle.
//   Output channel: done is high for exactly one cycle with the result on
//   kind, pac_index, row, color, style, indent, attribute_index,
//   control_code, tab_spaces, char_first and char_second. Every transaction
//   yields exactly one result, in order.
//   Pipeline: the accepting edge loads the input register; the result register
//   is then loaded from it through the screen and decode logic, and done is
//   high while the result register holds the new result.
//   Throughput: one transaction per cycle, set by the single register stage
//   on each side of the decode logic.
//   Reset: arst_n clears both valid flags; payload registers are not reset.
//   The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
module caption_608_pair_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic [7:0] header_byte,
	input  logic [7:0] first_byte,
	input  logic [7:0] second_byte,
	output logic       done,
	output logic [3:0] kind,
	output logic [3:0] pac_index,
	output logic [3:0] row,
	output logic [2:0] color,
	output logic [1:0] style,
	output logic [4:0] indent,
	output logic [3:0] attribute_index,
	output logic [3:0] control_code,
	output logic [1:0] tab_spaces,
	output logic [6:0] char_first,
	output logic [6:0] char_second
);

	logic                 vld_s1;
	logic                 command_s1;
	logic [7:0]           header_s1;
	logic [7:0]           first_s1;
	logic [7:0]           second_s1;
	cpc_pkg::cpc_pair_t   pair;
	cpc_pkg::cpc_result_t res;
	logic                 vld_s2;
	cpc_pkg::cpc_result_t res_s2;

	assign busy = 1'b0;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			command_s1 <= command;
			header_s1  <= header_byte;
			first_s1   <= first_byte;
			second_s1  <= second_byte;
		end
	end

	cpc_screen u_screen (
		.command     (command_s1),
		.header_byte (header_s1),
		.first_byte  (first_s1),
		.second_byte (second_s1),
		.pair        (pair)
	);

	cpc_decode u_decode (
		.pair (pair),
		.res  (res)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= res;
		end
	end

	assign done            = vld_s2;
	assign kind            = res_s2.kind;
	assign pac_index       = res_s2.pac_index;
	assign row             = res_s2.row;
	assign color           = res_s2.color;
	assign style           = res_s2.style;
	assign indent          = res_s2.indent;
	assign attribute_index = res_s2.attribute_index;
	assign control_code    = res_s2.control_code;
	assign tab_spaces      = res_s2.tab_spaces;
	assign char_first      = res_s2.char_first;
	assign char_second     = res_s2.char_second;

endmodule

// ----- rtl/cpc_screen.sv -----
// ----------------------------------------------------------------------------
// cpc_screen
// Header, parity and padding checks; strips parity from both bytes.
// ----------------------------------------------------------------------------
module cpc_screen (
	input  logic               command,
	input  logic [7:0]         header_byte,
	input  logic [7:0]         first_byte,
	input  logic [7:0]         second_byte,
	output cpc_pkg::cpc_pair_t pair
);

	logic       hdr_ok;
	logic       b2_odd;
	logic [6:0] b1_fixed;
	logic       is_pad_hdr;
	logic       is_pad;

	// Packet header: valid bit set, type zero
	assign hdr_ok = header_byte[2] && (header_byte[1:0] == 2'b00);
	assign b2_odd = ^second_byte;

	// Bad parity on the first byte substitutes the fill code
	assign b1_fixed = (^first_byte) ? first_byte[6:0] : cpc_pkg::BAD_PARITY_SUB;

	assign is_pad_hdr = (header_byte == cpc_pkg::HDR_PAD_A) ||
		(header_byte == cpc_pkg::HDR_PAD_B) || (header_byte == cpc_pkg::HDR_PAD_C);
	assign is_pad = is_pad_hdr && (b1_fixed == 7'd0) && (second_byte[6:0] == 7'd0);

	// Bare pairs bypass all checks
	always_comb begin
		if (command) begin
			pair.drop = 1'b0;
			pair.b1   = first_byte[6:0];
		end else begin
			pair.drop = !hdr_ok || !b2_odd || is_pad;
			pair.b1   = b1_fixed;
		end
		pair.b2 = second_byte[6:0];
	end

endmodule

// ----- rtl/cpc_decode.sv -----
// ----------------------------------------------------------------------------
// cpc_decode
// Decodes a screened pair into ignored, PAC, attribute, control, special, character,
// tab or non-data results.
// ----------------------------------------------------------------------------
module cpc_decode (
	input  cpc_pkg::cpc_pair_t   pair,
	output cpc_pkg::cpc_result_t res
);

	logic [6:0] b1;
	logic [6:0] b2;
	logic       is_pac;
	logic       is_attr;
	logic       is_ctrl_grp;
	logic [3:0] pac_idx;
	logic [3:0] row_p1;
	logic [4:0] code;

	assign b1 = pair.b1;
	assign b2 = pair.b2;

	assign is_pac = ((b1 == 7'h10) && (b2 >= 7'h40) && (b2 <= 7'h5f)) ||
		((b1 >= 7'h11) && (b1 <= 7'h17) && (b2 >= 7'h40));
	assign is_attr = ((b1 == 7'h11) && (b2 >= 7'h20) && (b2 <= 7'h2f)) ||
		((b1 == 7'h17) && (b2 >= 7'h2e) && (b2 <= 7'h2f));
	assign is_ctrl_grp = (b1 == 7'h14) || (b1 == 7'h15) || (b1 == 7'h1c);

	assign pac_idx = {b1[2:0], b2[5]};
	assign row_p1  = cpc_pkg::ROW_PLUS_ONE[pac_idx];
	assign code    = b2[4:0];

	// Classification in priority order; unused fields stay zero
	always_comb begin
		res = '0;
		priority if (pair.drop) begin
			res.kind = cpc_pkg::KIND_IGNORED;
		end else if (is_pac) begin
			res.pac_index = pac_idx;
			if (row_p1 == 4'd0) begin
				res.kind = cpc_pkg::KIND_BAD_PAC;
			end else begin
				res.kind   = cpc_pkg::KIND_PAC;
				res.row    = row_p1 - 4'd1;
				res.color  = cpc_pkg::color_of(code);
				res.style  = cpc_pkg::style_of(code);
				res.indent = code[4] ? {code[3:0], 1'b0} : 5'd0;
			end
		end else if (is_attr) begin
			res.kind            = cpc_pkg::KIND_ATTRIBUTE;
			res.attribute_index = b2[3:0];
			res.color           = cpc_pkg::color_of({1'b0, b2[3:0]});
			res.style           = cpc_pkg::style_of({1'b0, b2[3:0]});
		end else if (is_ctrl_grp) begin
			if (b2 >= 7'h20 && b2 <= 7'h2f) begin
				res.kind         = cpc_pkg::KIND_CONTROL;
				res.control_code = b2[3:0];
			end else begin
				res.kind = cpc_pkg::KIND_UNKNOWN_CTRL;
			end
		end else if (b1 == 7'h11) begin
			res.kind = cpc_pkg::KIND_SPECIAL_NA;
		end else if (b1 == 7'h12) begin
			res.kind = cpc_pkg::KIND_SPECIAL_SF;
		end else if (b1 == 7'h13) begin
			res.kind = cpc_pkg::KIND_SPECIAL_PG;
		end else if (b1 >= 7'h20) begin
			res.kind        = cpc_pkg::KIND_CHARS;
			res.char_first  = b1;
			res.char_second = b2;
		end else if ((b1 == 7'h17) && (b2 >= 7'h21) && (b2 <= 7'h23)) begin
			res.kind       = cpc_pkg::KIND_TAB;
			res.tab_spaces = b2[1:0];
		end else begin
			res.kind = cpc_pkg::KIND_NONDATA;
		end
	end

endmodule
